// ----- rtl/mp2_pkg.sv -----
// ----------------------------------------------------------------------------
// mp2_pkg
// Shared constants and types for the 2x2 stride-2 int8 max pooling block.
// ----------------------------------------------------------------------------
package mp2_pkg;

    localparam int MAX_WIDTH    = 256;
    localparam int MAX_CHANNELS = 64;
    localparam int MAX_HEIGHT   = 4096;

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int CH_W     = $clog2(MAX_CHANNELS);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int HEIGHT_W = ROW_W + 1;
    localparam int WIDTH_W  = COL_W + 1;
    localparam int CHAN_W   = CH_W + 1;

    localparam int STORE_DEPTH = (MAX_WIDTH / 2) * MAX_CHANNELS;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    localparam int DATA_W = 8;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = HEIGHT_W;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

    // result queue
    localparam int OUT_DEPTH = 3;
    localparam int OUT_PW    = $clog2(OUT_DEPTH);
    localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

    typedef enum logic [1:0] {
        POOL_LOAD,
        POOL_FOLD,
        POOL_EMIT
    } pool_op_t;

    typedef struct packed {
        logic                     valid;
        pool_op_t                 op;
        logic signed [DATA_W-1:0] sample;
        logic [STORE_AW-1:0]      addr;
        logic                     last;
    } pool_stage_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } out_beat_t;

endpackage

// ----- rtl/mp2_ram.sv -----
// ----------------------------------------------------------------------------
// mp2_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module mp2_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read returns the old contents on a same-cycle write
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/max_pool_2x2_int8.sv -----
// ----------------------------------------------------------------------------
// max_pool_2x2_int8
// A pooled beat is offered once stage 1 has pushed it into the result queue.
// Throughput: one sample per cycle while the result queue has room; the line
// store is read in the accept cycle, written back in the next; same-entry forwarding.
// Reset: counters cleared, frame 2x2 with one channel; store is not cleared.
// Partial maxima live in a (MAX_WIDTH/2)*MAX_CHANNELS line store.
// ----------------------------------------------------------------------------
module max_pool_2x2_int8 (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       cfg_wr_en,
    input  logic [mp2_pkg::CFG_IDX_W-1:0]              cfg_index,
    input  logic [mp2_pkg::CFG_DATA_W-1:0]             cfg_data,
    input  logic                                       s_valid,
    output logic                                       s_ready,
    input  logic signed [mp2_pkg::DATA_W-1:0]          s_sample,
    output logic                                       m_valid,
    input  logic                                       m_ready,
    output logic signed [mp2_pkg::DATA_W-1:0]          m_pooled_value,
    output logic                                       m_frame_last
);

    import mp2_pkg::*;

    // configuration, held already clamped
    logic [HEIGHT_W-1:0] height_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic [CHAN_W-1:0]   chan_reg;
    logic [HEIGHT_W-1:0] height_in;
    logic [WIDTH_W-1:0]  width_in;
    logic [CHAN_W-1:0]   chan_in;

    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [CH_W-1:0]  ch_reg, ch_next;

    pool_stage_t p1_reg, p1_next;
    logic                     fwd_reg, fwd_next;
    logic signed [DATA_W-1:0] fwd_data_reg;

    logic                     s_accept;
    logic                     in_window;
    logic                     ch_end, col_end, row_end;
    logic                     tail;
    logic [STORE_AW-1:0]      rd_addr;
    logic                     rd_en;
    logic [DATA_W-1:0]        rd_data;
    logic signed [DATA_W-1:0] prev;
    logic signed [DATA_W-1:0] maxv;
    logic                     wr_en;
    logic signed [DATA_W-1:0] wr_data;

    out_beat_t         out_mem [OUT_DEPTH];
    logic [OUT_PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [OUT_CW-1:0] count_reg;
    logic              push, pop;
    logic [OUT_CW:0]   occupancy;

    // ------------------------------------------------------------------
    // configuration clamp
    // ------------------------------------------------------------------
    always_comb begin
        height_in = cfg_data[HEIGHT_W-1:0];
        if (height_in == '0) begin
            height_in = HEIGHT_W'(1);
        end else if (height_in > HEIGHT_W'(MAX_HEIGHT)) begin
            height_in = HEIGHT_W'(MAX_HEIGHT);
        end
        width_in = cfg_data[WIDTH_W-1:0];
        if (width_in == '0) begin
            width_in = WIDTH_W'(1);
        end else if (width_in > WIDTH_W'(MAX_WIDTH)) begin
            width_in = WIDTH_W'(MAX_WIDTH);
        end
        chan_in = cfg_data[CHAN_W-1:0];
        if (chan_in == '0) begin
            chan_in = CHAN_W'(1);
        end else if (chan_in > CHAN_W'(MAX_CHANNELS)) begin
            chan_in = CHAN_W'(MAX_CHANNELS);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_reg <= HEIGHT_W'(2);
            width_reg  <= WIDTH_W'(2);
            chan_reg   <= CHAN_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FRAME_HEIGHT:  height_reg <= height_in;
                CFG_FRAME_WIDTH:   width_reg  <= width_in;
                CFG_CHANNEL_COUNT: chan_reg   <= chan_in;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // position counters and stage 0 (store read)
    // ------------------------------------------------------------------
    assign occupancy = (OUT_CW + 1)'(count_reg) + (OUT_CW + 1)'(p1_reg.valid);
    assign s_ready   = occupancy < (OUT_CW + 1)'(OUT_DEPTH);
    assign s_accept  = s_valid && s_ready;

    assign ch_end  = ch_reg == CH_W'(chan_reg - CHAN_W'(1));
    assign col_end = col_reg == COL_W'(width_reg - WIDTH_W'(1));
    assign row_end = row_reg == ROW_W'(height_reg - HEIGHT_W'(1));

    assign in_window = ({1'b0, row_reg} < {height_reg[HEIGHT_W-1:1], 1'b0}) &&
                       ({1'b0, col_reg} < {width_reg[WIDTH_W-1:1], 1'b0});

    assign tail = (HEIGHT_W'(row_reg) + HEIGHT_W'(1) == {height_reg[HEIGHT_W-1:1], 1'b0}) &&
                  (WIDTH_W'(col_reg) + WIDTH_W'(1) == {width_reg[WIDTH_W-1:1], 1'b0}) &&
                  ch_end;

    assign rd_addr = {col_reg[COL_W-1:1], ch_reg};

    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        ch_next  = ch_reg;
        if (cfg_wr_en && (cfg_index inside {CFG_FRAME_HEIGHT, CFG_FRAME_WIDTH,
                                            CFG_CHANNEL_COUNT})) begin
            // any register write restarts the frame
            row_next = '0;
            col_next = '0;
            ch_next  = '0;
        end else if (s_accept) begin
            if (ch_end) begin
                ch_next = '0;
                if (col_end) begin
                    col_next = '0;
                    row_next = row_end ? '0 : row_reg + ROW_W'(1);
                end else begin
                    col_next = col_reg + COL_W'(1);
                end
            end else begin
                ch_next = ch_reg + CH_W'(1);
            end
        end
    end

    always_comb begin
        p1_next        = p1_reg;
        p1_next.valid  = s_accept && in_window;
        p1_next.sample = s_sample;
        p1_next.addr   = rd_addr;
        p1_next.last   = tail;
        if (!row_reg[0] && !col_reg[0]) begin
            p1_next.op = POOL_LOAD;
        end else if (row_reg[0] && col_reg[0]) begin
            p1_next.op = POOL_EMIT;
        end else begin
            p1_next.op = POOL_FOLD;
        end
    end

    assign rd_en    = p1_next.valid && (p1_next.op != POOL_LOAD);
    // the entry being written back this cycle is still stale in the RAM
    assign fwd_next = rd_en && wr_en && (p1_reg.addr == rd_addr);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg      <= '0;
            col_reg      <= '0;
            ch_reg       <= '0;
            p1_reg       <= '0;
            fwd_reg      <= 1'b0;
            fwd_data_reg <= '0;
        end else begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            ch_reg       <= ch_next;
            p1_reg       <= p1_next;
            fwd_reg      <= fwd_next;
            fwd_data_reg <= wr_data;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: fold and write back or emit
    // ------------------------------------------------------------------
    assign prev = fwd_reg ? fwd_data_reg : $signed(rd_data);
    assign maxv = (p1_reg.sample > prev) ? p1_reg.sample : prev;

    assign wr_en   = p1_reg.valid && (p1_reg.op != POOL_EMIT);
    assign wr_data = (p1_reg.op == POOL_LOAD) ? p1_reg.sample : maxv;

    mp2_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (p1_reg.addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // result queue
    // ------------------------------------------------------------------
    assign push = p1_reg.valid && (p1_reg.op == POOL_EMIT);
    assign pop  = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            out_mem[wr_ptr_reg].value <= maxv;
            out_mem[wr_ptr_reg].last  <= p1_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == OUT_PW'(OUT_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + OUT_PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == OUT_PW'(OUT_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + OUT_PW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + OUT_CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - OUT_CW'(1);
            end
        end
    end

    assign m_valid        = count_reg != '0;
    assign m_pooled_value = out_mem[rd_ptr_reg].value;
    assign m_frame_last   = out_mem[rd_ptr_reg].last;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg != OUT_CW'(OUT_DEPTH)) || pop)
        else $error("result queue overflow");

    a_fwd_has_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_reg |-> p1_reg.valid && (p1_reg.op != POOL_LOAD))
        else $error("forward flag without a reading stage");

    a_last_on_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_reg.valid && p1_reg.last |-> p1_reg.op == POOL_EMIT)
        else $error("frame end flag on a non-emitting sample");

    a_load_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && in_window && !row_reg[0] && !col_reg[0]
            |=> p1_reg.valid && (p1_reg.op == POOL_LOAD))
        else $error("top-left sample of a window not loaded");

endmodule

// ----- test/max_pool_2x2_int8_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_pool_2x2_int8_checker
// Watches the configuration port and both beat channels of the pooling
// block. It keeps its own line store and frame counters, predicts every
// pooled beat, and compares each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module max_pool_2x2_int8_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [mp2_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mp2_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic signed [mp2_pkg::DATA_W-1:0]  s_sample,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic signed [mp2_pkg::DATA_W-1:0]  m_pooled_value,
    input  logic                               m_frame_last,
    output int                                 fail_count,
    output int                                 pending
);
    import mp2_pkg::*;

    logic signed [DATA_W-1:0] line_max [STORE_DEPTH];
    logic [HEIGHT_W-1:0]      frame_rows;
    logic [WIDTH_W-1:0]       frame_cols;
    logic [CHAN_W-1:0]        frame_chans;
    int unsigned              row_pos;
    int unsigned              col_pos;
    int unsigned              chan_pos;
    out_beat_t                pooled_q [$];
    int                       errors;

    initial begin
        errors = 0;
    end

    function automatic int unsigned clip(input int unsigned v, input int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Fold one sample into the line store; queue a pooled beat on the
    // odd column of the odd row.
    task automatic fold_sample(input logic signed [DATA_W-1:0] s);
        int unsigned rows;
        int unsigned cols;
        int unsigned nch;
        int unsigned used_rows;
        int unsigned used_cols;
        int unsigned idx;
        logic signed [DATA_W-1:0] m;
        out_beat_t beat;
        rows      = clip(frame_rows, MAX_HEIGHT);
        cols      = clip(frame_cols, MAX_WIDTH);
        nch       = clip(frame_chans, MAX_CHANNELS);
        used_rows = (rows / 2) * 2;
        used_cols = (cols / 2) * 2;
        if (row_pos < used_rows && col_pos < used_cols) begin
            idx = (col_pos / 2) * MAX_CHANNELS + chan_pos;
            if (row_pos % 2 == 0 && col_pos % 2 == 0) begin
                line_max[idx] = s;
            end else begin
                m = line_max[idx];
                if (s > m) m = s;
                if (row_pos % 2 == 1 && col_pos % 2 == 1) begin
                    beat.value = m;
                    beat.last  = (row_pos == used_rows - 1) && (col_pos == used_cols - 1) &&
                                 (chan_pos == nch - 1);
                    pooled_q.push_back(beat);
                end else begin
                    line_max[idx] = m;
                end
            end
        end
        // advance channel, then column, then row
        chan_pos++;
        if (chan_pos >= nch) begin
            chan_pos = 0;
            col_pos++;
            if (col_pos >= cols) begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= rows) row_pos = 0;
            end
        end
    endtask

    always @(posedge aclk) begin : watch
        out_beat_t want;
        logic      hit;
        hit = 1'b0;
        if (!aresetn) begin
            frame_rows  = 2;
            frame_cols  = 2;
            frame_chans = 1;
            row_pos     = 0;
            col_pos     = 0;
            chan_pos    = 0;
            pooled_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_FRAME_HEIGHT: begin
                        frame_rows = cfg_data[HEIGHT_W-1:0];
                        hit = 1'b1;
                    end
                    CFG_FRAME_WIDTH: begin
                        frame_cols = cfg_data[WIDTH_W-1:0];
                        hit = 1'b1;
                    end
                    CFG_CHANNEL_COUNT: begin
                        frame_chans = cfg_data[CHAN_W-1:0];
                        hit = 1'b1;
                    end
                    default: ;
                endcase
                // a register write restarts the frame, the store is kept
                if (hit) begin
                    row_pos  = 0;
                    col_pos  = 0;
                    chan_pos = 0;
                end
            end
            if (s_valid && s_ready) fold_sample(s_sample);
            if (m_valid && m_ready) begin
                if (pooled_q.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, got value %0d last %0b",
                             $time, m_pooled_value, m_frame_last);
                    errors++;
                end else begin
                    want = pooled_q.pop_front();
                    if (m_pooled_value !== want.value) begin
                        $display("%0t: pooled_value mismatch, expected %0d, got %0d",
                                 $time, want.value, m_pooled_value);
                        errors++;
                    end
                    if (m_frame_last !== want.last) begin
                        $display("%0t: frame_last mismatch, expected %0b, got %0b",
                                 $time, want.last, m_frame_last);
                        errors++;
                    end
                end
            end
        end
        fail_count <= errors;
        pending    <= pooled_q.size();
    end

endmodule

// ----- test/max_pool_2x2_int8_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_pool_2x2_int8_tb
// Drives sample frames of many shapes into the pooling block, with random
// gaps on both channels and one long result stall, and reports the verdict
// from the failure count and pending predictions of the checker.
// ----------------------------------------------------------------------------
module max_pool_2x2_int8_tb;
    import mp2_pkg::*;

    logic                        aclk;
    logic                        aresetn;
    logic                        cfg_wr_en;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;
    logic                        s_valid;
    logic                        s_ready;
    logic signed [DATA_W-1:0]    s_sample;
    logic                        m_valid;
    logic                        m_ready;
    logic signed [DATA_W-1:0]    m_pooled_value;
    logic                        m_frame_last;
    int                          fail_count;
    int                          pending;
    bit                          quiet;
    bit                          long_hold;

    max_pool_2x2_int8 uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pooled_value (m_pooled_value),
        .m_frame_last   (m_frame_last)
    );

    max_pool_2x2_int8_checker pool_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pooled_value (m_pooled_value),
        .m_frame_last   (m_frame_last),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5000000;
        $display("*** FAILED ***");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial begin : sink
        int gap;
        bit held;
        held    = 1'b0;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        m_ready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (long_hold && !held) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                m_ready <= 1'b1;
                held = 1'b1;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                gap = $urandom_range(1, 13);
                repeat (gap) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    function automatic logic signed [DATA_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return -8'sd128;
            1:       return 8'sd127;
            default: return DATA_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one beat, with an optional gap before it, and hold until taken.
    task automatic send_sample(input logic signed [DATA_W-1:0] v);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 13);
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= v;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid, wait for every predicted beat, then let the pipe settle.
    task automatic drain_to_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (10) @(posedge aclk);
    endtask

    task automatic set_frame(input logic [CFG_DATA_W-1:0] h, input logic [CFG_DATA_W-1:0] w,
                             input logic [CFG_DATA_W-1:0] c);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_FRAME_HEIGHT;
        cfg_data  <= h;
        @(posedge aclk);
        cfg_index <= CFG_FRAME_WIDTH;
        cfg_data  <= w;
        @(posedge aclk);
        cfg_index <= CFG_CHANNEL_COUNT;
        cfg_data  <= c;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin : stimulus
        int n;
        int phase;
        int sent;
        logic [CFG_DATA_W-1:0] h;
        logic [CFG_DATA_W-1:0] w;
        logic [CFG_DATA_W-1:0] c;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_FRAME_HEIGHT;
        cfg_data  = '0;
        s_valid   = 1'b0;
        s_sample  = '0;
        quiet     = 1'b0;
        long_hold = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset frame is 2x2 with one channel: max first, max last, all minimum
        send_sample(8'sd127);
        repeat (3) send_sample(-8'sd128);
        repeat (3) send_sample(-8'sd128);
        send_sample(8'sd127);
        repeat (4) send_sample(-8'sd128);

        // odd trailing row and column are dropped
        drain_to_idle();
        set_frame(3, 3, 1);
        repeat (9) send_sample(rand_sample());

        // out-of-range registers saturate; height of one gives no window
        drain_to_idle();
        set_frame(0, 8191, 0);
        repeat (4) send_sample(rand_sample());

        phase = 0;
        sent  = 0;
        while (sent < 1350) begin
            if (phase == 0) begin
                h = 4;
                w = 8;
                c = 2;
                n = 64;
            end else begin
                case ($urandom_range(0, 11))
                    8: begin
                        h = 2;
                        w = CFG_DATA_W'(($urandom_range(0, 1) == 0) ? 256
                                                                    : $urandom_range(257, 511));
                        c = 1;
                        n = 512;
                    end
                    9: begin
                        h = 2;
                        w = 2;
                        c = CFG_DATA_W'($urandom_range(64, 127));
                        n = 256;
                    end
                    10, 11: begin
                        case ($urandom_range(0, 3))
                            0:       h = 0;
                            1:       h = 1;
                            2:       h = 4096;
                            default: h = CFG_DATA_W'($urandom_range(4097, 8191));
                        endcase
                        w = CFG_DATA_W'(($urandom_range(0, 3) == 0) ? 0
                                                                    : $urandom_range(0, 8191));
                        c = CFG_DATA_W'(($urandom_range(0, 3) == 0) ? 0
                                                                    : $urandom_range(0, 8191));
                        n = $urandom_range(10, 60);
                    end
                    default: begin
                        h = CFG_DATA_W'($urandom_range(1, 6));
                        w = CFG_DATA_W'($urandom_range(1, 8));
                        c = CFG_DATA_W'($urandom_range(1, 4));
                        // whole frames, sometimes a few extra samples cut short
                        n = $urandom_range(1, 3) * h * w * c + $urandom_range(0, 3);
                    end
                endcase
            end
            // keep the total close to the planned item count
            if (n > 1350 - sent) n = 1350 - sent;
            drain_to_idle();
            set_frame(h, w, c);
            if (phase == 0) long_hold = 1'b1;
            repeat (n) begin
                if (sent >= 1200) quiet = 1'b1;
                send_sample(rand_sample());
                sent++;
            end
            phase++;
        end

        drain_to_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
